@@ rtl/fsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specifier parser package
// Shared constants, character codes and the beat types that pass between
// the classifier front end, the parser back end and the queues.
// ----------------------------------------------------------------------------
package fsp_pkg;

   // Default width of the width and precision accumulators.
   localparam int NUMBER_BITS_DEFAULT = 16;

   // Queue depths between the stages.
   localparam int TOKEN_DEPTH = 2;
   localparam int RSP_DEPTH   = 2;

   // Character codes.
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ELL   = 8'h6C;

   // Positions of the flags in the flag mask.
   localparam int FLAG_MINUS = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_ZERO  = 3;
   localparam int FLAG_HASH  = 4;
   localparam int FLAG_COUNT = 5;

   // Byte counter saturation value.
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // A classified character, as handed from the front end to the back end.
   typedef struct packed {
      logic [7:0]            character;
      logic                  first;
      logic [FLAG_COUNT-1:0] flag_mask;
      logic                  is_digit;
      logic [3:0]            digit;
      logic                  is_dot;
      logic                  is_ell;
   } token_type;

   // One finished specifier.
   typedef struct packed {
      logic        left_align;
      logic        force_sign;
      logic        space_sign;
      logic        zero_pad;
      logic        alternate_form;
      logic [15:0] field_width;
      logic [16:0] precision_value;
      logic        long_length;
      logic [7:0]  conversion_char;
      logic [7:0]  consumed_count;
      logic        overflowed;
   } rsp_type;

endpackage

@@ rtl/fsp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specifier parser queue
// A small register queue with push/full on the write side and pop/empty on
// the read side. When not empty, the oldest entry is shown on the read data.
// ----------------------------------------------------------------------------
module fsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/fsp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specifier parser front end
// Classifies each incoming character (flag, digit, dot, length letter) and
// queues the classified beat for the parser back end.
// ----------------------------------------------------------------------------
module fsp_front
   import fsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_character,
   input  logic       req_first,
   output logic       req_full,
   input  logic       tok_pop,
   output token_type  tok_data,
   output logic       tok_empty
);

   token_type tok_in;
   logic [$bits(token_type)-1:0] tok_rd;

   // Character classification.
   always_comb begin
      tok_in           = '0;
      tok_in.character = req_character;
      tok_in.first     = req_first;
      tok_in.flag_mask[FLAG_MINUS] = (req_character == CHAR_MINUS);
      tok_in.flag_mask[FLAG_PLUS]  = (req_character == CHAR_PLUS);
      tok_in.flag_mask[FLAG_SPACE] = (req_character == CHAR_SPACE);
      tok_in.flag_mask[FLAG_ZERO]  = (req_character == CHAR_ZERO);
      tok_in.flag_mask[FLAG_HASH]  = (req_character == CHAR_HASH);
      tok_in.is_digit  = (req_character >= CHAR_ZERO) && (req_character <= CHAR_NINE);
      tok_in.digit     = req_character[3:0];
      tok_in.is_dot    = (req_character == CHAR_DOT);
      tok_in.is_ell    = (req_character == CHAR_ELL);
   end

   // Queue toward the back end.
   fsp_fifo #(
      .WIDTH ($bits(token_type)),
      .DEPTH (TOKEN_DEPTH)
   ) u_token_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (tok_in),
      .full    (req_full),
      .pop     (tok_pop),
      .rd_data (tok_rd),
      .empty   (tok_empty)
   );

   assign tok_data = token_type'(tok_rd);

endmodule

@@ rtl/fsp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specifier parser back end
// Holds the parse state, applies one classified beat per cycle while the result
// queue has room, and queues a finished specifier whenever a character ends it.
// ----------------------------------------------------------------------------
module fsp_back
   import fsp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_data,
   input  logic      tok_empty,
   output logic      tok_pop,
   input  logic      rsp_pop,
   output rsp_type   rsp_data,
   output logic      rsp_empty
);

   localparam int NB  = NUMBER_BITS;
   localparam int EXT = NUMBER_BITS + 17;

   typedef enum logic [1:0] {
      PH_FLAGS,
      PH_WIDTH,
      PH_PREC,
      PH_AFTER_LEN
   } phase_type;

   phase_type             phase_ff, phase_in, ph_cur, ph_num;
   logic [FLAG_COUNT-1:0] flags_ff, flags_in, flags_cur;
   logic [NB-1:0]         width_ff, width_in, width_cur;
   logic [NB-1:0]         prec_ff, prec_in, prec_cur;
   logic                  prec_valid_ff, prec_valid_in, prec_valid_cur;
   logic                  long_ff, long_in, long_cur;
   logic [7:0]            count_ff, count_in, count_cur;
   logic                  ovf_ff, ovf_in, ovf_cur;

   logic [7:0]            cons_count;
   logic                  cons_ovf;
   logic [NB-1:0]         acc_sel;
   logic [NB+3:0]         acc_ext, acc_next;
   logic                  dig_sat;
   logic [NB-1:0]         dig_val;
   logic [EXT-1:0]        width_ext, prec_ext;
   logic                  ends, rsp_full, step;
   rsp_type               rsp_in;
   logic [$bits(rsp_type)-1:0] rsp_rd;

   // A beat is taken only when a result could be queued for it.
   assign step    = !tok_empty && !rsp_full;
   assign tok_pop = step;

   // Starting point: the held state, or the cleared state on a first beat.
   always_comb begin
      if (tok_data.first) begin
         ph_cur         = PH_FLAGS;
         flags_cur      = '0;
         width_cur      = '0;
         prec_cur       = '0;
         prec_valid_cur = 1'b0;
         long_cur       = 1'b0;
         count_cur      = '0;
         ovf_cur        = 1'b0;
      end else begin
         ph_cur         = phase_ff;
         flags_cur      = flags_ff;
         width_cur      = width_ff;
         prec_cur       = prec_ff;
         prec_valid_cur = prec_valid_ff;
         long_cur       = long_ff;
         count_cur      = count_ff;
         ovf_cur        = ovf_ff;
      end
   end

   // Saturating byte count.
   always_comb begin
      cons_ovf   = (count_cur == COUNT_MAX);
      cons_count = cons_ovf ? COUNT_MAX : count_cur + 8'd1;
   end

   // One shared multiply-by-ten and add for width and precision digits.
   always_comb begin
      acc_sel  = (ph_cur == PH_PREC) ? prec_cur : width_cur;
      acc_ext  = (NB + 4)'(acc_sel);
      acc_next = (acc_ext << 3) + (acc_ext << 1) + (NB + 4)'(tok_data.digit);
      dig_sat  = |acc_next[NB+3:NB];
      dig_val  = dig_sat ? '1 : acc_next[NB-1:0];
   end

   // Parse step.
   always_comb begin
      phase_in      = ph_cur;
      flags_in      = flags_cur;
      width_in      = width_cur;
      prec_in       = prec_cur;
      prec_valid_in = prec_valid_cur;
      long_in       = long_cur;
      count_in      = cons_count;
      ovf_in        = ovf_cur | cons_ovf;
      ends          = 1'b0;
      ph_num        = (ph_cur == PH_FLAGS) ? PH_WIDTH : ph_cur;

      if (ph_cur == PH_FLAGS && (|tok_data.flag_mask)) begin
         flags_in = flags_cur | tok_data.flag_mask;
      end else if (ph_num == PH_WIDTH && tok_data.is_digit) begin
         phase_in = PH_WIDTH;
         width_in = dig_val;
         ovf_in   = ovf_cur | cons_ovf | dig_sat;
      end else if (ph_num == PH_WIDTH && tok_data.is_dot) begin
         phase_in      = PH_PREC;
         prec_in       = '0;
         prec_valid_in = 1'b1;
      end else if (ph_num == PH_PREC && tok_data.is_digit) begin
         prec_in = dig_val;
         ovf_in  = ovf_cur | cons_ovf | dig_sat;
      end else if (ph_num != PH_AFTER_LEN && tok_data.is_ell) begin
         phase_in = PH_AFTER_LEN;
         long_in  = 1'b1;
      end else begin
         // Ending character: report and clear.
         ends          = 1'b1;
         phase_in      = PH_FLAGS;
         flags_in      = '0;
         width_in      = '0;
         prec_in       = '0;
         prec_valid_in = 1'b0;
         long_in       = 1'b0;
         count_in      = '0;
         ovf_in        = 1'b0;
      end
   end

   // Result beat, built from the state before the ending character.
   always_comb begin
      width_ext = EXT'(width_cur);
      prec_ext  = EXT'(prec_cur);
      rsp_in.left_align      = flags_cur[FLAG_MINUS];
      rsp_in.force_sign      = flags_cur[FLAG_PLUS];
      rsp_in.space_sign      = flags_cur[FLAG_SPACE];
      rsp_in.zero_pad        = flags_cur[FLAG_ZERO];
      rsp_in.alternate_form  = flags_cur[FLAG_HASH];
      rsp_in.field_width     = width_ext[15:0];
      rsp_in.precision_value = prec_valid_cur ? prec_ext[16:0] : '1;
      rsp_in.long_length     = long_cur;
      rsp_in.conversion_char = tok_data.character;
      rsp_in.consumed_count  = count_cur;
      rsp_in.overflowed      = ovf_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FLAGS;
         flags_ff      <= '0;
         width_ff      <= '0;
         prec_ff       <= '0;
         prec_valid_ff <= 1'b0;
         long_ff       <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         flags_ff      <= flags_in;
         width_ff      <= width_in;
         prec_ff       <= prec_in;
         prec_valid_ff <= prec_valid_in;
         long_ff       <= long_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
      end
   end

   // Result queue toward the output ports.
   fsp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (step && ends),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_rd);

endmodule

@@ rtl/format_spec_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specifier parser
// Parses the characters after a percent sign into flags, width, precision,
// length mark, ending character and consumed count.
// ----------------------------------------------------------------------------
// Push one character per beat, with req_first set on the first character of a
// specifier. Flags, width digits, a dot with precision digits and a single
// lower-case l are consumed silently; the first other character (NUL too)
// ends the specifier and produces one result beat carrying the parsed fields
// and that character, after which a new specifier begins. While the result
// queue has room, the block sustains one character per clock cycle: the
// front end classifies and queues each beat, and the back end applies it
// with a single multiply-by-ten-and-add per cycle. A result is read from a
// register queue on the rsp_ ports, and two-entry queues on each side let
// input and output stall independently. Width and precision saturate at
// 2^NUMBER_BITS - 1 and the count at 255, setting rsp_overflowed.
// ----------------------------------------------------------------------------
module format_spec_parser
   import fsp_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_character,
   input  logic               req_first,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_left_align,
   output logic               rsp_force_sign,
   output logic               rsp_space_sign,
   output logic               rsp_zero_pad,
   output logic               rsp_alternate_form,
   output logic [15:0]        rsp_field_width,
   output logic signed [16:0] rsp_precision_value,
   output logic               rsp_long_length,
   output logic [7:0]         rsp_conversion_char,
   output logic [7:0]         rsp_consumed_count,
   output logic               rsp_overflowed
);

   token_type tok_data;
   logic      tok_empty;
   logic      tok_pop;
   rsp_type   rsp_data;

   // Classifier front end.
   fsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_character (req_character),
      .req_first     (req_first),
      .req_full      (req_full),
      .tok_pop       (tok_pop),
      .tok_data      (tok_data),
      .tok_empty     (tok_empty)
   );

   // Parser back end.
   fsp_back #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_data  (tok_data),
      .tok_empty (tok_empty),
      .tok_pop   (tok_pop),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   // Result fields.
   assign rsp_left_align      = rsp_data.left_align;
   assign rsp_force_sign      = rsp_data.force_sign;
   assign rsp_space_sign      = rsp_data.space_sign;
   assign rsp_zero_pad        = rsp_data.zero_pad;
   assign rsp_alternate_form  = rsp_data.alternate_form;
   assign rsp_field_width     = rsp_data.field_width;
   assign rsp_precision_value = $signed(rsp_data.precision_value);
   assign rsp_long_length     = rsp_data.long_length;
   assign rsp_conversion_char = rsp_data.conversion_char;
   assign rsp_consumed_count  = rsp_data.consumed_count;
   assign rsp_overflowed      = rsp_data.overflowed;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format specifier parser testbench
// Streams format characters into the parser through its push/full queue
// port, with directed cases, random well-formed specifiers and random noise.
// A built-in parser model predicts each finished specifier. A popping
// process compares every result beat field by field against the oldest
// prediction. Random gaps on the push side and random stalls on the pop side
// exercise the queues.
// ----------------------------------------------------------------------------
module tb;
   import fsp_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int NOISE_ITEMS     = 300;
   localparam int DECIMAL_MAX     = (1 << NUMBER_BITS_DEFAULT) - 1;
   localparam int CHAR_COUNT_MAX  = COUNT_MAX;

   // Position of the parser within one specifier.
   typedef enum logic [1:0] {
      SCAN_FLAGS,
      SCAN_WIDTH,
      SCAN_PRECISION,
      SCAN_AFTER_LENGTH
   } scan_phase_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_character = 8'h00;
   logic               req_first = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic               rsp_left_align;
   logic               rsp_force_sign;
   logic               rsp_space_sign;
   logic               rsp_zero_pad;
   logic               rsp_alternate_form;
   logic [15:0]        rsp_field_width;
   logic signed [16:0] rsp_precision_value;
   logic               rsp_long_length;
   logic [7:0]         rsp_conversion_char;
   logic [7:0]         rsp_consumed_count;
   logic               rsp_overflowed;

   // Parse state of the model.
   scan_phase_type     scan_phase = SCAN_FLAGS;
   logic [FLAG_COUNT-1:0] flags_seen = '0;
   int                 width_acc = 0;
   int                 precision_acc = -1;
   logic               ell_seen = 1'b0;
   int                 char_count = 0;
   logic               saturated = 1'b0;

   // Finished specifiers waiting for their result beat.
   rsp_type            pending_specs[$];

   int                 mismatch_count = 0;
   int                 chars_sent = 0;
   int                 idle_cycles = 0;
   int                 pop_hold = 0;
   bit                 req_gaps_on = 1'b0;
   bit                 rsp_stalls_on = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   format_spec_parser #(
      .NUMBER_BITS(NUMBER_BITS_DEFAULT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_character      (req_character),
      .req_first          (req_first),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_left_align     (rsp_left_align),
      .rsp_force_sign     (rsp_force_sign),
      .rsp_space_sign     (rsp_space_sign),
      .rsp_zero_pad       (rsp_zero_pad),
      .rsp_alternate_form (rsp_alternate_form),
      .rsp_field_width    (rsp_field_width),
      .rsp_precision_value(rsp_precision_value),
      .rsp_long_length    (rsp_long_length),
      .rsp_conversion_char(rsp_conversion_char),
      .rsp_consumed_count (rsp_consumed_count),
      .rsp_overflowed     (rsp_overflowed)
   );

   // Idle length: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_parse();
      scan_phase    = SCAN_FLAGS;
      flags_seen    = '0;
      width_acc     = 0;
      precision_acc = -1;
      ell_seen      = 1'b0;
      char_count    = 0;
      saturated     = 1'b0;
   endfunction

   // One decimal digit into an accumulator, saturating at the maximum.
   function automatic int add_decimal(input int acc, input int digit);
      int sum;
      sum = acc * 10 + digit;
      if (acc > DECIMAL_MAX || sum > DECIMAL_MAX) begin
         saturated = 1'b1;
         return DECIMAL_MAX;
      end
      return sum;
   endfunction

   function automatic void count_char();
      if (char_count >= CHAR_COUNT_MAX) begin
         char_count = CHAR_COUNT_MAX;
         saturated  = 1'b1;
      end else begin
         char_count++;
      end
   endfunction

   // Applies one character to the model; done is set when it ends a specifier.
   function automatic void parse_char(input logic [7:0] c, input logic start,
                                      output bit done, output rsp_type spec);
      logic is_digit;
      int   digit;
      int   flag_pos;
      done = 1'b0;
      spec = '0;
      if (start) clear_parse();
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      digit    = int'(c) - int'(CHAR_ZERO);

      // Flags, with the zero digit counted as a flag only here.
      if (scan_phase == SCAN_FLAGS) begin
         case (c)
            CHAR_MINUS: flag_pos = FLAG_MINUS;
            CHAR_PLUS:  flag_pos = FLAG_PLUS;
            CHAR_SPACE: flag_pos = FLAG_SPACE;
            CHAR_ZERO:  flag_pos = FLAG_ZERO;
            CHAR_HASH:  flag_pos = FLAG_HASH;
            default:    flag_pos = -1;
         endcase
         if (flag_pos >= 0) begin
            flags_seen[flag_pos] = 1'b1;
            count_char();
            return;
         end
         scan_phase = SCAN_WIDTH;
      end

      // Width digits, the dot, and precision digits.
      if (scan_phase == SCAN_WIDTH) begin
         if (is_digit) begin
            width_acc = add_decimal(width_acc, digit);
            count_char();
            return;
         end
         if (c == CHAR_DOT) begin
            precision_acc = 0;
            scan_phase    = SCAN_PRECISION;
            count_char();
            return;
         end
      end else if (scan_phase == SCAN_PRECISION && is_digit) begin
         precision_acc = add_decimal(precision_acc, digit);
         count_char();
         return;
      end

      // A single length mark; whatever follows it ends the specifier.
      if (scan_phase != SCAN_AFTER_LENGTH && c == CHAR_ELL) begin
         ell_seen   = 1'b1;
         scan_phase = SCAN_AFTER_LENGTH;
         count_char();
         return;
      end

      // Ending character: report and start over.
      done                 = 1'b1;
      spec.left_align      = flags_seen[FLAG_MINUS];
      spec.force_sign      = flags_seen[FLAG_PLUS];
      spec.space_sign      = flags_seen[FLAG_SPACE];
      spec.zero_pad        = flags_seen[FLAG_ZERO];
      spec.alternate_form  = flags_seen[FLAG_HASH];
      spec.field_width     = width_acc[15:0];
      spec.precision_value = precision_acc[16:0];
      spec.long_length     = ell_seen;
      spec.conversion_char = c;
      spec.consumed_count  = char_count[7:0];
      spec.overflowed      = saturated;
      clear_parse();
   endfunction

   function automatic void check_field(input string field, input int expected,
                                       input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", field, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Pushes one character beat and records the specifier it finishes, if any.
   task automatic send_char(input logic [7:0] c, input logic start);
      int      gap;
      bit      done;
      rsp_type spec;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_character <= c;
      req_first     <= start;
      do @(posedge clock); while (req_full);
      parse_char(c, start, done, spec);
      if (done) pending_specs.push_back(spec);
      chars_sent++;
   endtask

   task automatic send_text(input string text, input logic start);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], start && i == 0);
      end
   endtask

   // Holds the push side until every finished specifier has come back.
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (pending_specs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Directed: flags, zero as flag and digit, length mark, bare dot, NUL,
   // restart, continuation after a result and width saturation.
   task automatic test_directed();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_text("d", 1'b1);
      send_text("-+ 0#x", 1'b1);
      send_text("08.3ld", 1'b1);
      send_text("ll", 1'b1);
      send_text(".", 1'b1);
      send_char(8'h00, 1'b0);
      send_text("5", 1'b1);
      send_text("d", 1'b1);
      send_text("x", 1'b0);
      send_text("70000d", 1'b1);
      send_char(8'hFF, 1'b1);
      wait_for_results();
   endtask

   // Random well-formed specifiers, with some aborted ones and a few very
   // long flag runs that drive the character count into saturation.
   task automatic test_random_specifiers();
      string      conversions;
      logic [7:0] chars[$];
      string      flag_chars;
      int         n_flags;
      int         n_digits;
      int         spec_index;
      bit         restart_due;
      conversions = "diouxXcsfeEgGp%n";
      flag_chars  = "-+ 0#";
      spec_index  = 0;
      restart_due = 1'b0;
      while (chars_sent < RANDOM_ITEMS) begin
         if (spec_index % 100 == 0) begin
            req_gaps_on   = $urandom_range(0, 3) != 0;
            rsp_stalls_on = $urandom_range(0, 3) != 0;
         end
         chars = {};
         if (spec_index == 0 || $urandom_range(0, 149) == 0)
            n_flags = $urandom_range(250, 280);
         else
            n_flags = $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0;
         repeat (n_flags) chars.push_back(flag_chars[$urandom_range(0, 4)]);
         n_digits = $urandom_range(0, 19) == 0 ? $urandom_range(5, 8)
                                               : $urandom_range(0, 3);
         repeat (n_digits) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         if ($urandom_range(0, 1)) begin
            chars.push_back(CHAR_DOT);
            n_digits = $urandom_range(0, 19) == 0 ? $urandom_range(5, 8)
                                                  : $urandom_range(0, 3);
            repeat (n_digits) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 2) == 0) chars.push_back(CHAR_ELL);
         if ($urandom_range(0, 4) != 0)
            chars.push_back(conversions[$urandom_range(0, conversions.len() - 1)]);
         else
            chars.push_back(8'($urandom_range(0, 255)));
         // Now and then cut the specifier short; the next one must restart.
         if ($urandom_range(0, 19) == 0) chars = chars[0:$urandom_range(0, chars.size() - 1)];
         foreach (chars[i]) begin
            send_char(chars[i], i == 0 && (restart_due || $urandom_range(0, 9) != 0));
         end
         restart_due = $urandom_range(0, 19) == 0;
         if ($urandom_range(0, 49) == 0) wait_for_results();
         spec_index++;
      end
      wait_for_results();
   endtask

   // Random bytes with a bias toward the characters the parser consumes.
   task automatic test_noise();
      string      parse_chars;
      logic [7:0] c;
      parse_chars   = "-+ 0#.l123456789d";
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (NOISE_ITEMS) begin
         if ($urandom_range(0, 1))
            c = 8'($urandom_range(0, 255));
         else
            c = parse_chars[$urandom_range(0, parse_chars.len() - 1)];
         send_char(c, $urandom_range(0, 9) == 0);
      end
      wait_for_results();
   endtask

   // Result side: random pop stalls and a field-by-field check of each beat.
   always @(posedge clock) begin
      rsp_type spec;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_specs.size() == 0) begin
            $error("result beat with no specifier pending, char %0d",
                   rsp_conversion_char);
            mismatch_count++;
         end else begin
            spec = pending_specs.pop_front();
            check_field("left_align", int'(spec.left_align), int'(rsp_left_align));
            check_field("force_sign", int'(spec.force_sign), int'(rsp_force_sign));
            check_field("space_sign", int'(spec.space_sign), int'(rsp_space_sign));
            check_field("zero_pad", int'(spec.zero_pad), int'(rsp_zero_pad));
            check_field("alternate_form", int'(spec.alternate_form),
                        int'(rsp_alternate_form));
            check_field("field_width", int'(spec.field_width), int'(rsp_field_width));
            check_field("precision_value", int'($signed(spec.precision_value)),
                        int'(rsp_precision_value));
            check_field("long_length", int'(spec.long_length), int'(rsp_long_length));
            check_field("conversion_char", int'(spec.conversion_char),
                        int'(rsp_conversion_char));
            check_field("consumed_count", int'(spec.consumed_count),
                        int'(rsp_consumed_count));
            check_field("overflowed", int'(spec.overflowed), int'(rsp_overflowed));
         end
      end
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop  <= 1'b1;
         pop_hold <= rsp_stalls_on ? pick_gap() : 0;
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("** format_spec_parser: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_specifiers();
      test_noise();
      if (pending_specs.size() != 0) begin
         $error("%0d specifiers never came back", pending_specs.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("** format_spec_parser: PASSED **");
      else
         $display("** format_spec_parser: FAILED **");
      $finish;
   end

endmodule
